FILE: rtl/ptir_pkg.sv
`default_nettype none

package ptir_pkg;

   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 40;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_DUP    = 2'd2;
   localparam logic [1:0] STATUS_BADIDX = 2'd3;

   typedef struct packed {
      logic [3:0]  position;
      logic [15:0] value_in;
      logic [15:0] key_in;
      logic [1:0]  opcode;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  entry_count;
      logic [15:0] value_out;
      logic [15:0] key_out;
      logic [1:0]  status;
   } rsp_data_type;

endpackage

`default_nettype wire

FILE: rtl/ptir_ram.sv
`default_nettype none

module ptir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/pair_table_insert_remove_top.sv
// channel   ports                            direction  contents
// req       req_tvalid/req_tready/req_tdata  in         opcode, key, value, position
// rsp       rsp_tvalid/rsp_tready/rsp_tdata  out        status, key, value, entry count
// csr       csr_valid/csr_ready/csr_data     in         allow_duplicates
//
// add without duplicate check, bad index, full, opcode 3: idle, done; read adds fetch
// add with duplicate check: adds scan of all entries; remove: adds fetch, then shift
// the walks go through the single read port of the pair ram, one entry a cycle
// reset clears the count and sets allow_duplicates; pair ram contents are not cleared
// a held response does not block the next request until that one is finished
`default_nettype none

module pair_table_insert_remove_top #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // opcode[1:0], key_in[17:2], value_in[33:18], position[37:34], zero fill
   input  wire logic [ptir_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // status[1:0], key_out[17:2], value_out[33:18], entry_count[38:34], zero fill
   output logic      [ptir_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_data
);

   localparam int KB = KEY_BITS < 16 ? KEY_BITS : 16;
   localparam int VB = VALUE_BITS < 16 ? VALUE_BITS : 16;
   localparam int AW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW > 4 ? CW : 4;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   op_ff, op_in;
   logic [KB-1:0] key_ff, key_in;
   logic [VB-1:0] val_ff, val_in;
   logic [3:0]   pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [CW-1:0] wptr_ff, wptr_in;
   logic         pend_ff, pend_in;
   logic         dup_ff, dup_in;
   logic [1:0]   status_ff, status_in;
   logic [KB-1:0] kout_ff, kout_in;
   logic [VB-1:0] vout_ff, vout_in;
   logic         allow_ff, allow_in;
   logic         rsp_valid_ff, rsp_valid_in;
   ptir_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   ptir_pkg::req_data_type req_fields;
   logic          accept;
   logic          issue;
   logic          load_rsp;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [KB+VB-1:0] wr_data;
   logic [KB+VB-1:0] rd_data;

   assign req_fields = ptir_pkg::req_data_type'(req_tdata[37:0]);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (walk_ff < count_ff);
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign allow_in   = csr_valid ? csr_data : allow_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   ptir_ram #(
      .WIDTH(KB + VB),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      walk_in   = walk_ff;
      wptr_in   = wptr_ff;
      pend_in   = pend_ff;
      dup_in    = dup_ff;
      status_in = status_ff;
      kout_in   = kout_ff;
      vout_in   = vout_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = {key_ff, val_ff};
      rd_addr   = walk_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_fields.opcode;
               key_in    = req_fields.key_in[KB-1:0];
               val_in    = req_fields.value_in[VB-1:0];
               pos_in    = req_fields.position;
               kout_in   = '0;
               vout_in   = '0;
               status_in = ptir_pkg::STATUS_OK;
               state_in  = ST_DONE;
               case (req_fields.opcode)
                  ptir_pkg::OP_ADD: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = ptir_pkg::STATUS_FULL;
                     end else if (!allow_ff && (count_ff != '0)) begin
                        walk_in  = '0;
                        pend_in  = 1'b0;
                        dup_in   = 1'b0;
                        state_in = ST_SCAN;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = {req_fields.key_in[KB-1:0], req_fields.value_in[VB-1:0]};
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ptir_pkg::OP_REMOVE, ptir_pkg::OP_READ: begin
                     if (PW'(req_fields.position) >= PW'(count_ff)) begin
                        status_in = ptir_pkg::STATUS_BADIDX;
                     end else begin
                        rd_addr  = AW'(req_fields.position);
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               walk_in = walk_ff + 1'b1;
            end
            if (pend_ff && (rd_data == {key_ff, val_ff})) begin
               dup_in = 1'b1;
            end
            if (!issue && !pend_ff) begin
               if (dup_ff) begin
                  status_in = ptir_pkg::STATUS_DUP;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_FETCH: begin
            kout_in = rd_data[KB+VB-1:VB];
            vout_in = rd_data[VB-1:0];
            if (op_ff == ptir_pkg::OP_REMOVE) begin
               wptr_in  = CW'(pos_ff);
               walk_in  = CW'(pos_ff) + 1'b1;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            pend_in = issue;
            if (issue) begin
               walk_in = walk_ff + 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wptr_ff[AW-1:0];
               wr_data = rd_data;
               wptr_in = wptr_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff;
      if (load_rsp) begin
         rsp_data_in.status      = status_ff;
         rsp_data_in.key_out     = 16'(kout_ff);
         rsp_data_in.value_out   = 16'(vout_ff);
         rsp_data_in.entry_count = 5'(count_ff);
         rsp_valid_in            = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         allow_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         allow_ff     <= allow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      walk_ff     <= walk_in;
      wptr_ff     <= wptr_in;
      pend_ff     <= pend_in;
      dup_ff      <= dup_in;
      status_ff   <= status_in;
      kout_ff     <= kout_in;
      vout_ff     <= vout_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE || state_ff == ST_SCAN || state_ff == ST_SHIFT))
      else $error("pair ram written outside an update state");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (wptr_ff < walk_ff))
      else $error("shift write pointer not behind read pointer");

   a_dup_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !dup_ff && dup_in |-> pend_ff)
      else $error("duplicate flagged without a compared entry");

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished request not presented");

endmodule

`default_nettype wire

FILE: test/pair_table_insert_remove_top_tb.sv
`timescale 1ns / 1ps

module pair_table_insert_remove_top_tb;

   localparam int          TABLE_DEPTH   = 16;
   localparam logic [1:0]  OP_IDLE       = 2'd3;
   localparam int          HOLD_OFF_LEN  = 250;
   localparam int          QUIET_LIMIT   = 3000;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          PHASE_ITEMS   = 260;
   localparam int          REPORT_LIMIT  = 10;

   typedef enum logic {ROW_REQUEST, ROW_POLICY} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      ptir_pkg::req_data_type req;
      int                     reps;
      bit                     typed;
      ptir_pkg::rsp_data_type want;
      bit                     policy;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [ptir_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [ptir_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic                                csr_data = 1'b0;

   logic [15:0]  stored_keys [TABLE_DEPTH];
   logic [15:0]  stored_values [TABLE_DEPTH];
   logic [4:0]   stored_count = '0;
   bit           dup_allowed = 1'b1;

   ptir_pkg::rsp_data_type pending_outcomes [$];
   stim_row_type           directed_rows [$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           hold_off_requests = 0;
   bit           steady_flow = 1'b0;

   pair_table_insert_remove_top #(
      .CAPACITY  (TABLE_DEPTH),
      .KEY_BITS  (16),
      .VALUE_BITS(16)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic ptir_pkg::rsp_data_type table_apply(ptir_pkg::req_data_type r);
      ptir_pkg::rsp_data_type o;
      bit           hit;
      int           i;
      o = '0;
      o.status = ptir_pkg::STATUS_OK;
      hit = 1'b0;
      case (r.opcode)
         ptir_pkg::OP_ADD: begin
            if (stored_count >= TABLE_DEPTH) begin
               o.status = ptir_pkg::STATUS_FULL;
            end else begin
               if (!dup_allowed) begin
                  for (i = 0; i < stored_count; i++) begin
                     if (stored_keys[i] == r.key_in && stored_values[i] == r.value_in) begin
                        hit = 1'b1;
                     end
                  end
               end
               if (hit) begin
                  o.status = ptir_pkg::STATUS_DUP;
               end else begin
                  stored_keys[stored_count] = r.key_in;
                  stored_values[stored_count] = r.value_in;
                  stored_count++;
               end
            end
         end
         ptir_pkg::OP_REMOVE, ptir_pkg::OP_READ: begin
            if (r.position >= stored_count) begin
               o.status = ptir_pkg::STATUS_BADIDX;
            end else begin
               o.key_out = stored_keys[r.position];
               o.value_out = stored_values[r.position];
               if (r.opcode == ptir_pkg::OP_REMOVE) begin
                  for (i = r.position; i + 1 < stored_count; i++) begin
                     stored_keys[i] = stored_keys[i + 1];
                     stored_values[i] = stored_values[i + 1];
                  end
                  stored_count--;
               end
            end
         end
         default: begin
         end
      endcase
      o.entry_count = stored_count;
      return o;
   endfunction

   function automatic ptir_pkg::req_data_type draw_request(int add_pct);
      ptir_pkg::req_data_type r;
      int           pick;
      r.key_in = 16'($urandom_range(0, 65535));
      r.value_in = 16'($urandom_range(0, 65535));
      r.position = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 4) begin
         r.opcode = OP_IDLE;
      end else if ($urandom_range(0, 99) < add_pct) begin
         r.opcode = ptir_pkg::OP_ADD;
         pick = $urandom_range(0, 3);
         if (pick == 0 && stored_count > 0) begin
            pick = $urandom_range(0, stored_count - 1);
            r.key_in = stored_keys[pick];
            r.value_in = stored_values[pick];
         end else if (pick == 1) begin
            r.key_in = 16'($urandom_range(0, 3));
            r.value_in = 16'($urandom_range(0, 3));
         end
      end else begin
         r.opcode = $urandom_range(0, 1) ? ptir_pkg::OP_REMOVE : ptir_pkg::OP_READ;
         if (stored_count > 0 && $urandom_range(0, 99) < 85) begin
            r.position = 4'($urandom_range(0, stored_count - 1));
         end
      end
      return r;
   endfunction

   task automatic offer_request(input ptir_pkg::req_data_type r, input bit typed,
                                input ptir_pkg::rsp_data_type want);
      int           gap;
      ptir_pkg::rsp_data_type pred;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(ptir_pkg::REQ_TDATA_BITS - $bits(ptir_pkg::req_data_type)){1'b0}}, r};
      do @(posedge clock); while (!req_tready);
      pred = table_apply(r);
      pending_outcomes.insert(pending_outcomes.size(), typed ? want : pred);
   endtask

   task automatic write_dup_policy(input bit allow);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= allow;
      do @(posedge clock); while (!csr_ready);
      dup_allowed = allow;
      csr_valid <= 1'b0;
   endtask

   task automatic put_row(input row_kind_type kind, input logic [1:0] op,
                          input logic [15:0] key,
                          input logic [15:0] value, input logic [3:0] pos, input int reps,
                          input bit typed, input logic [1:0] status, input logic [15:0] kout,
                          input logic [15:0] vout, input logic [4:0] count);
      stim_row_type row;
      row.kind = kind;
      row.req.opcode = op;
      row.req.key_in = key;
      row.req.value_in = value;
      row.req.position = pos;
      row.reps = reps;
      row.typed = typed;
      row.want.status = status;
      row.want.key_out = kout;
      row.want.value_out = vout;
      row.want.entry_count = count;
      row.policy = key[0];
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic compare_outcome(input ptir_pkg::rsp_data_type got);
      ptir_pkg::rsp_data_type want;
      if (pending_outcomes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected response: status %0d key %h value %h count %0d",
                     got.status, got.key_out, got.value_out, got.entry_count);
         end
      end else begin
         want = pending_outcomes.pop_front();
         if (got.status !== want.status || got.key_out !== want.key_out ||
             got.value_out !== want.value_out || got.entry_count !== want.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("mismatch: want status %0d key %h value %h count %0d",
                        want.status, want.key_out, want.value_out, want.entry_count);
               $display("          got  status %0d key %h value %h count %0d",
                        got.status, got.key_out, got.value_out, got.entry_count);
            end
         end
      end
   endtask

   // response side: random stalls plus the long hold-off
   initial begin : response_side
      int gap_left;
      int hold_left;
      int hold_off_served;
      gap_left = 0;
      hold_left = 0;
      hold_off_served = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            compare_outcome(
               ptir_pkg::rsp_data_type'(rsp_tdata[$bits(ptir_pkg::rsp_data_type)-1:0]));
            gap_left = steady_flow ? 0 : $urandom_range(0, 4);
         end
         if (hold_off_requests != hold_off_served) begin
            hold_off_served++;
            hold_left = HOLD_OFF_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                     n;
      int                     phase;
      int                     add_pct [5];
      ptir_pkg::req_data_type r;
      ptir_pkg::rsp_data_type none;
      none = '0;
      add_pct = '{70, 55, 35, 75, 25};

      // empty table, then a short fill with duplicates allowed
      put_row(ROW_REQUEST, ptir_pkg::OP_READ,   16'h0000, 16'h0000, 4'd0,  1, 1,
              ptir_pkg::STATUS_BADIDX, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_REMOVE, 16'h0000, 16'h0000, 4'd15, 1, 1,
              ptir_pkg::STATUS_BADIDX, 0, 0, 0);
      put_row(ROW_REQUEST, OP_IDLE,             16'hFFFF, 16'hFFFF, 4'd15, 1, 1,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'hFFFF, 16'h0000, 4'd0,  1, 1,
              ptir_pkg::STATUS_OK, 0, 0, 1);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'h0000, 16'hFFFF, 4'd0,  1, 1,
              ptir_pkg::STATUS_OK, 0, 0, 2);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'hFFFF, 16'h0000, 4'd0,  1, 1,
              ptir_pkg::STATUS_OK, 0, 0, 3);
      put_row(ROW_REQUEST, ptir_pkg::OP_READ,   16'h0000, 16'h0000, 4'd0,  1, 1,
              ptir_pkg::STATUS_OK, 16'hFFFF, 16'h0000, 3);
      put_row(ROW_REQUEST, ptir_pkg::OP_READ,   16'h0000, 16'h0000, 4'd3,  1, 1,
              ptir_pkg::STATUS_BADIDX, 0, 0, 3);
      put_row(ROW_REQUEST, ptir_pkg::OP_REMOVE, 16'h0000, 16'h0000, 4'd0,  1, 1,
              ptir_pkg::STATUS_OK, 16'hFFFF, 16'h0000, 2);
      // duplicates refused from here, allowed again by the last row
      put_row(ROW_POLICY,  ptir_pkg::OP_ADD,    16'h0000, 16'h0000, 4'd0,  1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'h0000, 16'hFFFF, 4'd0,  1, 1,
              ptir_pkg::STATUS_DUP, 0, 0, 2);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 4'd0,  1, 1,
              ptir_pkg::STATUS_OK, 0, 0, 3);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'h1000, 16'hA5A5, 4'd0, 13, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'h0000, 16'hFFFF, 4'd0,  1, 1,
              ptir_pkg::STATUS_FULL, 0, 0, 16);
      put_row(ROW_REQUEST, ptir_pkg::OP_READ,   16'h0000, 16'h0000, 4'd15, 1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_REMOVE, 16'h0000, 16'h0000, 4'd15, 1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_REMOVE, 16'h0000, 16'h0000, 4'd0,  1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_REMOVE, 16'h0000, 16'h0000, 4'd7,  1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'h0000, 16'hFFFF, 4'd0,  1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);
      put_row(ROW_REQUEST, ptir_pkg::OP_ADD,    16'h0000, 16'hFFFF, 4'd0,  1, 1,
              ptir_pkg::STATUS_DUP, 0, 0, 14);
      put_row(ROW_POLICY,  ptir_pkg::OP_ADD,    16'h0001, 16'h0000, 4'd0,  1, 0,
              ptir_pkg::STATUS_OK, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_POLICY) begin
            write_dup_policy(directed_rows[i].policy);
         end else begin
            for (n = 0; n < directed_rows[i].reps; n++) begin
               r = directed_rows[i].req;
               r.key_in = r.key_in + 16'(n);
               offer_request(r, directed_rows[i].typed, directed_rows[i].want);
            end
         end
      end

      for (phase = 0; phase < 5; phase++) begin
         write_dup_policy(phase[0]);
         steady_flow = (phase == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 60) begin
               hold_off_requests++;
            end
            offer_request(draw_request(add_pct[phase]), 1'b0, none);
         end
      end
      steady_flow = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: pair_table_insert_remove_top.f
rtl/ptir_pkg.sv
rtl/ptir_ram.sv
rtl/pair_table_insert_remove_top.sv
test/pair_table_insert_remove_top_tb.sv
